// ----- design/stt_pkg.sv -----
// Package for the source text tokenizer: token and queue types, token kind
// and run mode codes, and the character classification helpers.
// Depends on nothing; every other design file but stt_ifaces imports it.
package stt_pkg;

    localparam logic [2:0] KIND_INT     = 3'd0;
    localparam logic [2:0] KIND_FLOAT   = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_KEYWORD = 3'd3;
    localparam logic [2:0] KIND_DELIM   = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_IDENT  = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;

    localparam logic [7:0] MAX_TOKEN_LEN = 8'd255;
    localparam logic [7:0] COLUMN_LAST   = 8'd255;
    localparam logic [9:0] LINE_WIDTH    = 10'd256;
    localparam logic [2:0] HEAD_CHARS    = 3'd5;

    localparam logic [23:0] WORD_INT   = 24'h746E69;
    localparam logic [39:0] WORD_FLOAT = 40'h74616F6C66;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] line;
        logic [8:0]  pos;
        logic [7:0]  len;
        logic [7:0]  single_char;
        logic [15:0] count;
    } token_t;

    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C, 8'h3B, 8'h3A};
    endfunction

    function automatic logic [8:0] pos_at(input logic [7:0] col, input logic [1:0] offset);
        logic [9:0] sum;
        sum = {2'b00, col} + {8'd0, offset};
        if (sum > LINE_WIDTH)
        begin
            sum = LINE_WIDTH;
        end
        return sum[8:0];
    endfunction

    function automatic logic [2:0] run_kind(input logic [1:0] mode, input logic [7:0] len,
                                            input logic [39:0] head, input logic dot);
        logic [2:0] kind;
        kind = KIND_IDENT;
        case (mode)
            MODE_IDENT:
            begin
                if ((len == 8'd3 && head[23:0] == WORD_INT) ||
                    (len == 8'd5 && head == WORD_FLOAT))
                begin
                    kind = KIND_KEYWORD;
                end
            end
            MODE_NUMBER: kind = dot ? KIND_FLOAT : KIND_INT;
            default:     kind = KIND_IDENT;
        endcase
        return kind;
    endfunction

endpackage

// ----- design/stt_ifaces.sv -----
// Handshake interfaces for the tokenizer: the character input channel and
// the token output channel. Depends on nothing.
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;

    modport source (output valid, output ch, output line_end, input ready);
    modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_line;
    logic [8:0]  token_pos;
    logic [7:0]  token_len;
    logic [7:0]  single_char;
    logic [15:0] token_count;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_line, output token_pos,
                    output token_len, output single_char, output token_count,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_line, input token_pos,
                  input token_len, input single_char, input token_count,
                  input last_of_run, output ready);
endinterface

// ----- design/stt_front.sv -----
// Classifier of the tokenizer: accepts one character a cycle while the queue
// is not full, tracks the open run, line and column, and pushes the tokens of
// each character as one word. Depends on stt_pkg and stt_ifaces.
module stt_front (
    input  logic              clk,
    input  logic              rst_n,
    stt_in_if.sink            src,
    input  stt_pkg::q_status_t q_status,
    output logic              push,
    output stt_pkg::entry_t   push_entry
);
    import stt_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  column_reg, column_next;
    logic [15:0] line_reg, line_next;
    logic        dot_reg, dot_next;
    logic [39:0] head_reg, head_next;
    logic [15:0] count_reg, count_next;

    logic        fire;
    logic        cont, run_open, close_a, single, close_e, open_after;
    logic [1:0]  mode_a;
    logic [7:0]  len_a;
    logic        dot_a;
    logic [39:0] head_a;
    token_t      tok_a, tok_s, tok_e;
    logic [1:0]  ntok;

    assign src.ready = !q_status.full;
    assign fire = src.valid && src.ready;

    always_comb
    begin
        run_open = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
        cont = ((mode_reg == MODE_IDENT) &&
                (is_letter(src.ch) || is_digit(src.ch) || src.ch == 8'h5F)) ||
               ((mode_reg == MODE_NUMBER) && (is_digit(src.ch) || src.ch == 8'h2E));
        close_a = !cont && run_open;
        single = 1'b0;
        mode_a = mode_reg;
        len_a = len_reg;
        dot_a = dot_reg;
        head_a = head_reg;

        if (cont)
        begin
            if (len_reg < {5'd0, HEAD_CHARS})
            begin
                head_a = head_reg | ({32'd0, src.ch} << {len_reg[2:0], 3'b000});
            end
            if (len_reg < MAX_TOKEN_LEN)
            begin
                len_a = len_reg + 8'd1;
            end
            if (src.ch == 8'h2E)
            begin
                dot_a = 1'b1;
            end
        end
        else
        begin
            mode_a = MODE_NONE;
            len_a = 8'd0;
            dot_a = 1'b0;
            head_a = 40'd0;
            if (is_letter(src.ch) || is_digit(src.ch))
            begin
                mode_a = is_letter(src.ch) ? MODE_IDENT : MODE_NUMBER;
                len_a = 8'd1;
                head_a = {32'd0, src.ch};
            end
            else if (!is_blank(src.ch))
            begin
                single = 1'b1;
            end
        end

        open_after = (mode_a == MODE_IDENT) || (mode_a == MODE_NUMBER);
        close_e = src.line_end && open_after;

        tok_a.kind = run_kind(mode_reg, len_reg, head_reg, dot_reg);
        tok_a.line = line_reg;
        tok_a.pos = pos_at(column_reg, 2'd1);
        tok_a.len = len_reg;
        tok_a.single_char = 8'd0;
        tok_a.count = 16'd0;

        tok_s.kind = is_delim(src.ch) ? KIND_DELIM : KIND_UNKNOWN;
        tok_s.line = line_reg;
        tok_s.pos = pos_at(column_reg, 2'd1);
        tok_s.len = 8'd1;
        tok_s.single_char = src.ch;
        tok_s.count = 16'd0;

        tok_e.kind = run_kind(mode_a, len_a, head_a, dot_a);
        tok_e.line = line_reg;
        tok_e.pos = pos_at(column_reg, 2'd2);
        tok_e.len = len_a;
        tok_e.single_char = 8'd0;
        tok_e.count = 16'd0;

        ntok = {1'b0, close_a} + {1'b0, single} + {1'b0, close_e};

        push_entry.two = (ntok == 2'd2);
        if (close_a)
        begin
            push_entry.tok0 = tok_a;
            push_entry.tok1 = single ? tok_s : tok_e;
        end
        else
        begin
            push_entry.tok0 = single ? tok_s : tok_e;
            push_entry.tok1 = tok_e;
        end
        push_entry.tok0.count = count_reg + 16'd1;
        push_entry.tok1.count = count_reg + 16'd2;
        push = fire && (ntok != 2'd0);

        mode_next = mode_a;
        len_next = len_a;
        dot_next = dot_a;
        head_next = head_a;
        column_next = column_reg;
        line_next = line_reg;
        if (src.line_end)
        begin
            mode_next = MODE_NONE;
            len_next = 8'd0;
            dot_next = 1'b0;
            head_next = 40'd0;
            column_next = 8'd0;
            line_next = line_reg + 16'd1;
        end
        else if (column_reg < COLUMN_LAST)
        begin
            column_next = column_reg + 8'd1;
        end
        count_next = count_reg + {14'd0, ntok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            len_reg <= 8'd0;
            column_reg <= 8'd0;
            line_reg <= 16'd0;
            dot_reg <= 1'b0;
            head_reg <= 40'd0;
            count_reg <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            len_reg <= len_next;
            column_reg <= column_next;
            line_reg <= line_next;
            dot_reg <= dot_next;
            head_reg <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/stt_queue.sv -----
// Short word queue between the classifier and the output stage of the
// tokenizer. Depends on stt_pkg.
module stt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stt_pkg::entry_t    push_entry,
    input  logic               pop,
    output stt_pkg::entry_t    head_entry,
    output stt_pkg::q_status_t status
);
    import stt_pkg::*;

    entry_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     fill_reg, fill_next;

    assign status.full = (fill_reg == QUEUE_DEPTH[QUEUE_AW:0]);
    assign status.empty = (fill_reg == '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- design/stt_back.sv -----
// Output stage of the tokenizer: sends the one or two tokens of the queue's
// head word in order and marks the last. Depends on stt_pkg and stt_ifaces.
module stt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::entry_t    head_entry,
    input  stt_pkg::q_status_t q_status,
    output logic               pop,
    stt_out_if.source          tok
);
    import stt_pkg::*;

    logic   second_reg;
    logic   fire;
    token_t cur;

    assign cur = second_reg ? head_entry.tok1 : head_entry.tok0;
    assign fire = tok.valid && tok.ready;
    assign pop = fire && (second_reg || !head_entry.two);

    assign tok.valid = !q_status.empty;
    assign tok.token_kind = cur.kind;
    assign tok.token_line = cur.line;
    assign tok.token_pos = cur.pos;
    assign tok.token_len = cur.len;
    assign tok.single_char = cur.single_char;
    assign tok.token_count = cur.count;
    assign tok.last_of_run = second_reg || !head_entry.two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else if (fire)
        begin
            second_reg <= !second_reg && head_entry.two;
        end
    end

endmodule

// ----- design/source_text_tokenizer.sv -----
// Top level of the source text tokenizer: classifier, word queue and output
// stage. Depends on stt_pkg, stt_ifaces, stt_front, stt_queue and stt_back.
//
// The tokenizer takes one character per cycle and gives tokens of kind
// integer, float, identifier, keyword, delimiter or unknown, each with its
// line, end position, length and running count. A character yields zero, one
// or two tokens; the classifier takes a character every cycle while the
// four-word queue in front of the output stage has room, and the output stage
// sends one token per cycle while the channel is ready, popping a two-token
// word after its second token. Input stalls only when that queue is full.
module source_text_tokenizer (
    input logic       clk,
    input logic       rst_n,
    stt_in_if.sink    src,
    stt_out_if.source tok
);
    import stt_pkg::*;

    logic      push, pop;
    entry_t    push_entry, head_entry;
    q_status_t q_status;

    stt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (src),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    stt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .tok        (tok)
    );

endmodule

// ----- design/stt_checker.sv -----
// Port-level checks for the tokenizer's token channel, attached to the top
// level by the bind statement below. Depends on stt_pkg and the top level's ports.
module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [2:0]  tok_kind,
    input logic [8:0]  tok_pos,
    input logic [7:0]  tok_len,
    input logic [7:0]  tok_char,
    input logic [15:0] tok_count
);
    import stt_pkg::*;

    logic [15:0] last_count_reg;
    logic        tok_fire;

    assign tok_fire = tok_valid && tok_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= 16'd0;
        end
        else if (tok_fire)
        begin
            last_count_reg <= tok_count;
        end
    end

    // A stalled token stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid)
        else $error("token withdrawn while stalled");

    // Tokens are numbered without gaps or repeats.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_fire |-> tok_count == last_count_reg + 16'd1)
        else $error("token count out of sequence");

    // Run tokens carry no character; single-character tokens have length one and a nonzero position.
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_kind != KIND_DELIM && tok_kind != KIND_UNKNOWN
        |-> tok_char == 8'd0)
        else $error("run token carries a character");

    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_kind == KIND_DELIM || tok_kind == KIND_UNKNOWN)
        |-> tok_len == 8'd1 && tok_pos != 9'd0)
        else $error("single-character token malformed");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok.valid),
    .tok_ready (tok.ready),
    .tok_kind  (tok.token_kind),
    .tok_pos   (tok.token_pos),
    .tok_len   (tok.token_len),
    .tok_char  (tok.single_char),
    .tok_count (tok.token_count)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for source_text_tokenizer: character words go in, token words come out.
// Uses stt_pkg and the stt_in_if / stt_out_if interfaces from the design.
module testbench;

    import stt_pkg::*;

    localparam int RANDOM_CHARS  = 235;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 32;
    localparam int REPORT_CAP    = 40;

    localparam logic [7:0] RUN_LEN_CAP = 8'd255;
    localparam logic [7:0] COL_LAST    = 8'd255;
    localparam logic [9:0] POS_CAP     = 10'd256;

    typedef struct packed {
        token_t tok;
        logic   last;
    } token_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
        logic       typed;
        token_t     want;
    } char_item_t;

    localparam char_item_t DIRECTED_TEXT [26] = '{
        '{8'h28, 1'b0, 1'b1, '{KIND_DELIM,   16'd0, 9'd1, 8'd1, 8'h28, 16'd1}},
        '{8'h00, 1'b0, 1'b1, '{KIND_UNKNOWN, 16'd0, 9'd2, 8'd1, 8'h00, 16'd2}},
        '{8'hFF, 1'b0, 1'b1, '{KIND_UNKNOWN, 16'd0, 9'd3, 8'd1, 8'hFF, 16'd3}},
        '{8'h0D, 1'b0, 1'b0, '0},
        '{"i",   1'b0, 1'b0, '0},
        '{"n",   1'b0, 1'b0, '0},
        '{"t",   1'b0, 1'b0, '0},
        '{8'h09, 1'b0, 1'b0, '0},
        '{"f",   1'b0, 1'b0, '0},
        '{"l",   1'b0, 1'b0, '0},
        '{"o",   1'b0, 1'b0, '0},
        '{"a",   1'b0, 1'b0, '0},
        '{"t",   1'b0, 1'b0, '0},
        '{";",   1'b0, 1'b0, '0},
        '{"7",   1'b0, 1'b0, '0},
        '{".",   1'b0, 1'b0, '0},
        '{"5",   1'b1, 1'b0, '0},
        '{"_",   1'b0, 1'b1, '{KIND_UNKNOWN, 16'd1, 9'd1, 8'd1, 8'h5F, 16'd8}},
        '{".",   1'b0, 1'b1, '{KIND_UNKNOWN, 16'd1, 9'd2, 8'd1, 8'h2E, 16'd9}},
        '{"a",   1'b0, 1'b0, '0},
        '{"_",   1'b0, 1'b0, '0},
        '{"9",   1'b0, 1'b0, '0},
        '{"{",   1'b0, 1'b0, '0},
        '{"4",   1'b0, 1'b0, '0},
        '{"x",   1'b1, 1'b0, '0},
        '{")",   1'b1, 1'b1, '{KIND_DELIM,   16'd2, 9'd1, 8'd1, 8'h29, 16'd14}}
    };

    logic clk;
    logic rst_n;

    stt_in_if  char_bus ();
    stt_out_if token_bus ();

    source_text_tokenizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (char_bus),
        .tok   (token_bus)
    );

    char_item_t  text_queue [$];
    token_word_t pending_tokens [$];
    token_word_t typed_word;
    token_word_t arrived;

    logic [1:0]  open_mode;
    logic [7:0]  open_len;
    logic [7:0]  cur_col;
    logic [15:0] cur_line;
    logic        open_dot;
    logic [39:0] open_head;
    logic [15:0] token_total;

    int   error_count = 0;
    int   chars_taken = 0;
    int   tokens_seen = 0;
    int   lines_sent = 0;
    int   quiet_cycles = 0;
    int   kind_hits [8];
    logic stim_done = 1'b0;
    logic timed_out = 1'b0;

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic delim_char(input logic [7:0] c);
        return c inside {"(", ")", "{", "}", ",", ";", ":"};
    endfunction

    function automatic logic [8:0] pos_after(input logic [1:0] offset);
        logic [9:0] p;
        p = {2'b00, cur_col} + {8'd0, offset};
        if (p > POS_CAP)
        begin
            p = POS_CAP;
        end
        return p[8:0];
    endfunction

    task automatic report_error(input string what);
        if (error_count < REPORT_CAP)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
        begin
            report_error($sformatf("token %0d %s: got %0h, want %0h",
                                   tokens_seen, name, got, want));
        end
    endtask

    task automatic emit_token(input logic [2:0] kind, input logic [8:0] pos,
                              input logic [7:0] len, input logic [7:0] sc);
        token_word_t w;
        token_total = token_total + 16'd1;
        w.tok.kind = kind;
        w.tok.line = cur_line;
        w.tok.pos = pos;
        w.tok.len = len;
        w.tok.single_char = sc;
        w.tok.count = token_total;
        w.last = 1'b0;
        pending_tokens.push_back(w);
    endtask

    task automatic grow_run(input logic [7:0] c);
        if (open_len < 8'd5)
        begin
            open_head[open_len * 8 +: 8] = c;
        end
        if (open_len < RUN_LEN_CAP)
        begin
            open_len = open_len + 8'd1;
        end
        if (c == ".")
        begin
            open_dot = 1'b1;
        end
    endtask

    task automatic close_run(input logic [1:0] offset);
        logic [2:0] kind;
        if (open_mode == MODE_IDENT || open_mode == MODE_NUMBER)
        begin
            if (open_mode == MODE_NUMBER)
            begin
                kind = open_dot ? KIND_FLOAT : KIND_INT;
            end
            else if ((open_len == 8'd3 &&
                      {open_head[7:0], open_head[15:8], open_head[23:16]} == "int") ||
                     (open_len == 8'd5 &&
                      {open_head[7:0], open_head[15:8], open_head[23:16],
                       open_head[31:24], open_head[39:32]} == "float"))
            begin
                kind = KIND_KEYWORD;
            end
            else
            begin
                kind = KIND_IDENT;
            end
            emit_token(kind, pos_after(offset), open_len, 8'd0);
            open_mode = MODE_NONE;
            open_len = 8'd0;
            open_dot = 1'b0;
            open_head = 40'd0;
        end
    endtask

    task automatic tokenize_char(input logic [7:0] c, input logic eol);
        logic        continues_run;
        int          depth_in;
        token_word_t w;
        depth_in = pending_tokens.size();
        continues_run = 1'b0;
        if (open_mode == MODE_IDENT)
        begin
            continues_run = letter_char(c) || digit_char(c) || c == "_";
        end
        else if (open_mode == MODE_NUMBER)
        begin
            continues_run = digit_char(c) || c == ".";
        end

        if (continues_run)
        begin
            grow_run(c);
        end
        else
        begin
            close_run(2'd1);
            if (blank_char(c))
            begin
            end
            else if (delim_char(c))
            begin
                emit_token(KIND_DELIM, pos_after(2'd1), 8'd1, c);
            end
            else if (letter_char(c))
            begin
                open_mode = MODE_IDENT;
                grow_run(c);
            end
            else if (digit_char(c))
            begin
                open_mode = MODE_NUMBER;
                grow_run(c);
            end
            else
            begin
                emit_token(KIND_UNKNOWN, pos_after(2'd1), 8'd1, c);
            end
        end

        if (eol)
        begin
            close_run(2'd2);
            cur_col = 8'd0;
            cur_line = cur_line + 16'd1;
        end
        else if (cur_col < COL_LAST)
        begin
            cur_col = cur_col + 8'd1;
        end

        if (pending_tokens.size() > depth_in)
        begin
            w = pending_tokens.pop_back();
            w.last = 1'b1;
            pending_tokens.push_back(w);
        end
    endtask

    function automatic logic rare_eol();
        return $urandom_range(0, 11) == 0;
    endfunction

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0:       return pick_letter();
            1:       return pick_digit();
            2:       return "_";
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 6))
            0:       return "(";
            1:       return ")";
            2:       return "{";
            3:       return "}";
            4:       return ",";
            5:       return ";";
            default: return ":";
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? " " : 8'($urandom_range(9, 13));
    endfunction

    task automatic add_char(input logic [7:0] c, input logic eol);
        char_item_t item;
        item = '0;
        item.ch = c;
        item.line_end = eol;
        text_queue.push_back(item);
    endtask

    task automatic add_word(input string w);
        for (int i = 0; i < w.len(); i++)
        begin
            add_char(w[i], rare_eol());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        logic [15:0] stall_pattern;
        logic [3:0]  stall_step;
        stall_pattern = 16'hFFFF;
        stall_step = 4'd0;
        token_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_step == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom & $urandom);
                    default: stall_pattern = 16'($urandom | $urandom);
                endcase
                stall_pattern[0] = 1'b1;
            end
            token_bus.ready <= stall_pattern[stall_step];
            stall_step = stall_step + 4'd1;
        end
    end

    initial
    begin
        string word;
        int    random_start;
        int    sent;
        int    burst;
        int    gap;

        char_bus.valid = 1'b0;
        char_bus.ch = 8'd0;
        char_bus.line_end = 1'b0;
        rst_n = 1'b0;
        open_mode = MODE_NONE;
        open_len = 8'd0;
        cur_col = 8'd0;
        cur_line = 16'd0;
        open_dot = 1'b0;
        open_head = 40'd0;
        token_total = 16'd0;
        foreach (kind_hits[k])
        begin
            kind_hits[k] = 0;
        end

        foreach (DIRECTED_TEXT[i])
        begin
            text_queue.push_back(DIRECTED_TEXT[i]);
        end

        // One line longer than the column range. Its first run starts out spelling a
        // keyword and runs past the length cap; the last run is closed by the line end.
        word = "float";
        for (int i = 0; i < word.len(); i++)
        begin
            add_char(word[i], 1'b0);
        end
        repeat (260) add_char(pick_word_char(), 1'b0);
        add_char(" ", 1'b0);
        add_char("8", 1'b0);
        repeat (20) add_char(($urandom_range(0, 9) == 0) ? "." : pick_digit(), 1'b0);
        add_char(";", 1'b0);
        add_char("6", 1'b0);
        add_char(pick_digit(), 1'b1);

        random_start = text_queue.size();
        while (text_queue.size() < random_start + RANDOM_CHARS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        word = "int";
                    end
                    else
                    begin
                        word = "float";
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        word = word.substr(0, word.len() - 2);
                    end
                    else if ($urandom_range(0, 5) == 0)
                    begin
                        word = word.toupper();
                    end
                    add_word(word);
                end
                2, 3:
                begin
                    add_char(pick_letter(), rare_eol());
                    repeat ($urandom_range(0, 8)) add_char(pick_word_char(), rare_eol());
                end
                4, 5:
                begin
                    add_char(pick_digit(), rare_eol());
                    repeat ($urandom_range(0, 6))
                    begin
                        add_char(($urandom_range(0, 4) == 0) ? "." : pick_digit(), rare_eol());
                    end
                end
                6:       add_char(pick_delim(), rare_eol());
                7:       add_char(pick_blank(), rare_eol());
                8:       add_char(8'($urandom_range(0, 255)), rare_eol());
                default: add_char($urandom_range(0, 1) ? "_" : ".", rare_eol());
            endcase
            if ($urandom_range(0, 2) != 0)
            begin
                add_char($urandom_range(0, 1) ? pick_blank() : pick_delim(), rare_eol());
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sent = 0;
        while (sent < text_queue.size())
        begin
            burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                char_bus.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            while (burst > 0 && sent < text_queue.size())
            begin
                char_bus.valid <= 1'b1;
                char_bus.ch <= text_queue[sent].ch;
                char_bus.line_end <= text_queue[sent].line_end;
                @(posedge clk);
                while (!char_bus.ready)
                begin
                    @(posedge clk);
                end
                sent++;
                burst--;
                @(negedge clk);
            end
        end
        char_bus.valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                tokenize_char(char_bus.ch, char_bus.line_end);
                // A row with a typed-in token is checked against that token instead.
                if (text_queue[chars_taken].typed)
                begin
                    typed_word = pending_tokens.pop_back();
                    typed_word.tok = text_queue[chars_taken].want;
                    pending_tokens.push_back(typed_word);
                end
                if (char_bus.line_end)
                begin
                    lines_sent++;
                end
                chars_taken++;
            end

            if (token_bus.valid && token_bus.ready)
            begin
                tokens_seen++;
                kind_hits[token_bus.token_kind]++;
                if (pending_tokens.size() == 0)
                begin
                    report_error($sformatf("token %0d arrived with nothing expected",
                                           tokens_seen));
                end
                else
                begin
                    arrived = pending_tokens.pop_front();
                    check_field("kind", 16'(token_bus.token_kind), 16'(arrived.tok.kind));
                    check_field("line", token_bus.token_line, arrived.tok.line);
                    check_field("pos", 16'(token_bus.token_pos), 16'(arrived.tok.pos));
                    check_field("len", 16'(token_bus.token_len), 16'(arrived.tok.len));
                    check_field("char", 16'(token_bus.single_char),
                                16'(arrived.tok.single_char));
                    check_field("count", token_bus.token_count, arrived.tok.count);
                    check_field("last", 16'(token_bus.last_of_run), 16'(arrived.last));
                end
            end

            if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                timed_out = 1'b1;
            end
        end
    end

    initial
    begin
        while (!timed_out && !(stim_done && pending_tokens.size() == 0))
        begin
            @(posedge clk);
        end
        if (timed_out)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d tokens outstanding",
                     QUIET_LIMIT, pending_tokens.size());
            $display("testbench: errors");
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            while (pending_tokens.size() > 0)
            begin
                arrived = pending_tokens.pop_front();
                report_error($sformatf("token with count %0d never arrived", arrived.tok.count));
            end
            $display("Sent %0d characters over %0d lines; %0d tokens came back, %0d mismatches.",
                     chars_taken, lines_sent, tokens_seen, error_count);
            $display("Kinds seen: %0d int, %0d float, %0d ident, %0d keyword, %0d delim, %0d unknown.",
                     kind_hits[KIND_INT], kind_hits[KIND_FLOAT], kind_hits[KIND_IDENT],
                     kind_hits[KIND_KEYWORD], kind_hits[KIND_DELIM], kind_hits[KIND_UNKNOWN]);
            if (error_count == 0)
            begin
                $display("testbench: clean");
            end
            else
            begin
                $display("testbench: errors");
            end
        end
        $finish;
    end

endmodule
